// ----- sv/owc_pkg.sv -----
package owc_pkg;

  localparam int NUM_LINES      = 8;
  localparam int BYTE_GAP_TICKS = 5;
  localparam int READ_LOW_TICKS = 1;

  localparam int LINE_W = 3;
  localparam int TICK_W = 10;
  localparam int CFG_W  = 10;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_PRESENCE = 2'd0,
    STS_ABSENT   = 2'd1,
    STS_SHORTED  = 2'd2
  } rst_status_t;

  typedef enum logic [2:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_RESET_TAIL    = 3'd2,
    REG_ZERO_LOW      = 3'd3,
    REG_ONE_LOW       = 3'd4,
    REG_WRITE_SLOT    = 3'd5,
    REG_READ_SAMPLE   = 3'd6,
    REG_READ_TAIL     = 3'd7
  } cfg_idx_t;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_RST_LOW  = 7'b0000010,
    PH_RST_WAIT = 7'b0000100,
    PH_RST_TAIL = 7'b0001000,
    PH_WR_SLOT  = 7'b0010000,
    PH_WR_GAP   = 7'b0100000,
    PH_RD_SLOT  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [9:0] presence_wait_time;
    logic [9:0] reset_tail_time;
    logic [7:0] zero_low_time;
    logic [7:0] one_low_time;
    logic [7:0] write_slot_time;
    logic [7:0] read_sample_delay;
    logic [7:0] read_tail_time;
  } timing_t;

  typedef struct packed {
    logic              drive_low;
    logic [LINE_W-1:0] active_line;
    logic              busy_res;
    logic              done_res;
    logic [1:0]        reset_status;
    logic [7:0]        read_data;
  } result_t;

  function automatic logic [9:0] min1_10(input logic [9:0] v);
    return (v == 10'd0) ? 10'd1 : v;
  endfunction

  function automatic logic [7:0] min1_8(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage

// ----- sv/owc_cfg_regs.sv -----
module owc_cfg_regs (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [9:0]            cfg_data,
  output owc_pkg::timing_t      timing
);

  owc_pkg::timing_t timing_r;
  logic             wr_en;

  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid && cfg_ready;
  assign timing    = timing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.reset_low_time     <= 10'd480;
      timing_r.presence_wait_time <= 10'd66;
      timing_r.reset_tail_time    <= 10'd240;
      timing_r.zero_low_time      <= 8'd60;
      timing_r.one_low_time       <= 8'd10;
      timing_r.write_slot_time    <= 8'd64;
      timing_r.read_sample_delay  <= 8'd10;
      timing_r.read_tail_time     <= 8'd50;
    end else if (wr_en) begin
      unique case (owc_pkg::cfg_idx_t'(cfg_index))
        owc_pkg::REG_RESET_LOW:     timing_r.reset_low_time     <= cfg_data;
        owc_pkg::REG_PRESENCE_WAIT: timing_r.presence_wait_time <= cfg_data;
        owc_pkg::REG_RESET_TAIL:    timing_r.reset_tail_time    <= cfg_data;
        owc_pkg::REG_ZERO_LOW:      timing_r.zero_low_time      <= cfg_data[7:0];
        owc_pkg::REG_ONE_LOW:       timing_r.one_low_time       <= cfg_data[7:0];
        owc_pkg::REG_WRITE_SLOT:    timing_r.write_slot_time    <= cfg_data[7:0];
        owc_pkg::REG_READ_SAMPLE:   timing_r.read_sample_delay  <= cfg_data[7:0];
        owc_pkg::REG_READ_TAIL:     timing_r.read_tail_time     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/owc_seq.sv -----
module owc_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          line_level,
  input  logic [1:0]                    cmd,
  input  logic [owc_pkg::LINE_W-1:0]    line_index,
  input  logic [7:0]                    write_data,
  input  owc_pkg::timing_t              timing,
  output owc_pkg::result_t              res
);

  owc_pkg::phase_t                   phase_r, phase_nxt, ph;
  logic [owc_pkg::TICK_W-1:0]        tick_r, tick_nxt, tick;
  logic [3:0]                        bit_r, bit_nxt, bidx, bidx_inc;
  logic [7:0]                        shift_r, shift_nxt, sb;
  logic [1:0]                        status_r, status_nxt;
  logic [owc_pkg::LINE_W-1:0]        line_r, line_nxt;
  logic [7:0]                        rdata_r, rdata_nxt;
  logic                              start;
  logic [owc_pkg::TICK_W:0]          tick_inc;
  logic [7:0]                        wr_low;
  logic [8:0]                        wr_slot;
  logic [9:0]                        rd_sample;
  logic [9:0]                        rd_slot;

  always_comb begin
    ph       = phase_r;
    tick     = tick_r;
    bidx     = bit_r;
    sb       = shift_r;
    line_nxt = line_r;
    start    = (phase_r == owc_pkg::PH_IDLE) && (owc_pkg::cmd_t'(cmd) != owc_pkg::CMD_NONE) &&
               ({1'b0, line_index} < 4'(owc_pkg::NUM_LINES));
    if (start) begin
      line_nxt = line_index;
      tick     = '0;
      bidx     = '0;
      sb       = (owc_pkg::cmd_t'(cmd) == owc_pkg::CMD_WRITE) ? write_data : 8'd0;
      unique case (owc_pkg::cmd_t'(cmd))
        owc_pkg::CMD_RESET: ph = owc_pkg::PH_RST_LOW;
        owc_pkg::CMD_WRITE: ph = owc_pkg::PH_WR_SLOT;
        default:            ph = owc_pkg::PH_RD_SLOT;
      endcase
    end

    tick_inc  = {1'b0, tick} + 11'd1;
    bidx_inc  = bidx + 4'd1;
    wr_low    = sb[0] ? owc_pkg::min1_8(timing.one_low_time)
                      : owc_pkg::min1_8(timing.zero_low_time);
    wr_slot   = (timing.write_slot_time > wr_low) ? {1'b0, timing.write_slot_time}
                                                  : {1'b0, wr_low} + 9'd1;
    rd_sample = 10'(owc_pkg::READ_LOW_TICKS) + {2'b0, owc_pkg::min1_8(timing.read_sample_delay)}
                - 10'd1;
    rd_slot   = rd_sample + 10'd1 + {2'b0, owc_pkg::min1_8(timing.read_tail_time)};

    phase_nxt  = ph;
    tick_nxt   = tick;
    bit_nxt    = bidx;
    shift_nxt  = sb;
    status_nxt = status_r;
    rdata_nxt  = rdata_r;
    res.drive_low = 1'b0;
    res.done_res  = 1'b0;
    res.busy_res  = (ph != owc_pkg::PH_IDLE);

    unique case (ph)
      owc_pkg::PH_IDLE: ;
      owc_pkg::PH_RST_LOW: begin
        res.drive_low = 1'b1;
        if (tick_inc >= {1'b0, owc_pkg::min1_10(timing.reset_low_time)}) begin
          phase_nxt = owc_pkg::PH_RST_WAIT;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_inc[owc_pkg::TICK_W-1:0];
        end
      end
      owc_pkg::PH_RST_WAIT: begin
        // hold the presence sample in the shift register until the short check
        if (tick_inc >= {1'b0, owc_pkg::min1_10(timing.presence_wait_time)}) begin
          shift_nxt = {7'd0, line_level};
          phase_nxt = owc_pkg::PH_RST_TAIL;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_inc[owc_pkg::TICK_W-1:0];
        end
      end
      owc_pkg::PH_RST_TAIL: begin
        if (tick_inc >= {1'b0, owc_pkg::min1_10(timing.reset_tail_time)}) begin
          status_nxt   = line_level ? (sb[0] ? owc_pkg::STS_ABSENT : owc_pkg::STS_PRESENCE)
                                    : owc_pkg::STS_SHORTED;
          res.done_res = 1'b1;
          phase_nxt    = owc_pkg::PH_IDLE;
          tick_nxt     = '0;
        end else begin
          tick_nxt = tick_inc[owc_pkg::TICK_W-1:0];
        end
      end
      owc_pkg::PH_WR_SLOT: begin
        res.drive_low = ({1'b0, tick} < {3'b0, wr_low});
        if (tick_inc >= {2'b0, wr_slot}) begin
          shift_nxt = {1'b0, sb[7:1]};
          bit_nxt   = bidx_inc;
          tick_nxt  = '0;
          if (bidx_inc[3]) begin
            if (owc_pkg::BYTE_GAP_TICKS == 0) begin
              res.done_res = 1'b1;
              phase_nxt    = owc_pkg::PH_IDLE;
            end else begin
              phase_nxt = owc_pkg::PH_WR_GAP;
            end
          end
        end else begin
          tick_nxt = tick_inc[owc_pkg::TICK_W-1:0];
        end
      end
      owc_pkg::PH_WR_GAP: begin
        if (tick_inc >= 11'(owc_pkg::BYTE_GAP_TICKS)) begin
          res.done_res = 1'b1;
          phase_nxt    = owc_pkg::PH_IDLE;
          tick_nxt     = '0;
        end else begin
          tick_nxt = tick_inc[owc_pkg::TICK_W-1:0];
        end
      end
      owc_pkg::PH_RD_SLOT: begin
        res.drive_low = (tick < 10'(owc_pkg::READ_LOW_TICKS));
        if ((tick == rd_sample) && line_level) begin
          shift_nxt = sb | (8'd1 << bidx[2:0]);
        end
        if (tick_inc >= {1'b0, rd_slot}) begin
          bit_nxt  = bidx_inc;
          tick_nxt = '0;
          if (bidx_inc[3]) begin
            rdata_nxt    = shift_nxt;
            res.done_res = 1'b1;
            phase_nxt    = owc_pkg::PH_IDLE;
          end
        end else begin
          tick_nxt = tick_inc[owc_pkg::TICK_W-1:0];
        end
      end
      default: begin
        phase_nxt = owc_pkg::PH_IDLE;
        tick_nxt  = '0;
      end
    endcase

    res.active_line  = line_nxt;
    res.reset_status = status_nxt;
    res.read_data    = rdata_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= owc_pkg::PH_IDLE;
      tick_r   <= '0;
      bit_r    <= '0;
      shift_r  <= '0;
      status_r <= '0;
      line_r   <= '0;
      rdata_r  <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      tick_r   <= tick_nxt;
      bit_r    <= bit_nxt;
      shift_r  <= shift_nxt;
      status_r <= status_nxt;
      line_r   <= line_nxt;
      rdata_r  <= rdata_nxt;
    end
  end

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.done_res |-> res.busy_res)
    else $error("done without busy");

  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.drive_low |-> res.busy_res)
    else $error("line driven while idle");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (bit_r <= 4'd8))
    else $error("bit index past byte end");

  a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.done_res) |=> (phase_r == owc_pkg::PH_IDLE))
    else $error("sequencer not idle after completion");

endmodule

// ----- sv/owc_out_buf.sv -----
module owc_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              can_push,
  input  owc_pkg::result_t  push_res,
  output logic              out_valid,
  input  logic              out_ready,
  output owc_pkg::result_t  out_res
);

  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  owc_pkg::result_t out_res_r, skid_res_r;
  logic             pop;

  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign pop       = out_valid_r && out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (pop) begin
      out_valid_nxt  = skid_valid_r || push;
      skid_valid_nxt = skid_valid_r && push;
    end else if (push) begin
      out_valid_nxt  = 1'b1;
      skid_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // advance skid into the output slot first, keep arrival order
  always_ff @(posedge clk) begin
    if (pop && skid_valid_r) begin
      out_res_r <= skid_res_r;
    end else if (push && (!out_valid_r || pop)) begin
      out_res_r <= push_res;
    end
    if (push && out_valid_r && !(pop && !skid_valid_r)) begin
      skid_res_r <= push_res;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a request while output slot empty");

endmodule

// ----- sv/one_wire_bus_master_core.sv -----
// One-Wire bus master. Each accepted request is one microsecond tick carrying the sampled
// line level and an optional command (reset, write byte, read byte); each tick yields exactly
// one result describing the drive level, busy/done flags and the last reset status and read
// byte. A request is accepted every clock cycle while in_ready is high: the sequencer
// updates its phase and tick counter on each accepted request and the result is registered
// in a two-entry output buffer; in_ready drops only when both entries are full. Timing registers
// are written via the cfg_ port (always ready); the user must do so only while no command runs.
module one_wire_bus_master_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_line_level,
  input  logic [1:0]                  in_cmd,
  input  logic [owc_pkg::LINE_W-1:0]  in_line_index,
  input  logic [7:0]                  in_write_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_drive_low,
  output logic [owc_pkg::LINE_W-1:0]  out_active_line,
  output logic                        out_busy_res,
  output logic                        out_done_res,
  output logic [1:0]                  out_reset_status,
  output logic [7:0]                  out_read_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [2:0]                  cfg_index,
  input  logic [owc_pkg::CFG_W-1:0]   cfg_data
);

  owc_pkg::timing_t timing;
  owc_pkg::result_t seq_res, buf_res;
  logic             step;

  assign step = in_valid && in_ready;

  owc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .timing    (timing)
  );

  owc_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .line_level (in_line_level),
    .cmd        (in_cmd),
    .line_index (in_line_index),
    .write_data (in_write_data),
    .timing     (timing),
    .res        (seq_res)
  );

  owc_out_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .can_push  (in_ready),
    .push_res  (seq_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (buf_res)
  );

  assign out_drive_low    = buf_res.drive_low;
  assign out_active_line  = buf_res.active_line;
  assign out_busy_res     = buf_res.busy_res;
  assign out_done_res     = buf_res.done_res;
  assign out_reset_status = buf_res.reset_status;
  assign out_read_data    = buf_res.read_data;

endmodule
